// File: rtl/sorted_symbol_weight_table_unit_defines.svh
// Assertion macros shared by the sorted symbol weight table RTL.
`ifndef SORTED_SYMBOL_WEIGHT_TABLE_UNIT_DEFINES_SVH
`define SORTED_SYMBOL_WEIGHT_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define SSWT_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sswt assertion failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define SSWT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sswt assertion failed");
`else
`define SSWT_ASSERT_IMPL(label, clk, rst_n, a, b)
`define SSWT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: rtl/sswt_pkg.sv
// Package with the constants, codes and types of the sorted symbol weight table.
package sswt_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int SYM_W     = 8;
    localparam int WEIGHT_W  = 32;
    localparam int FRAC_W    = 16;
    localparam int TOTAL_W   = WEIGHT_W + IDX_W;
    localparam int DIVD_W    = WEIGHT_W + FRAC_W;
    localparam int DSTEP_W   = $clog2(DIVD_W + 1);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_GET   = 2'd2;
    localparam logic [1:0] OP_NORM  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic                we;
        logic [IDX_W-1:0]    waddr;
        logic [SYM_W-1:0]    wsym;
        logic [WEIGHT_W-1:0] wweight;
        logic [IDX_W-1:0]    raddr;
    } mem_req_t;

endpackage

// File: rtl/sswt_store.sv
// Entry store: symbol and weight memories with one write and one registered read port.
module sswt_store (
    input  logic                          clk,
    input  sswt_pkg::mem_req_t            req,
    output logic [sswt_pkg::SYM_W-1:0]    rd_sym,
    output logic [sswt_pkg::WEIGHT_W-1:0] rd_weight
);
    import sswt_pkg::*;

    logic [SYM_W-1:0]    sym_mem    [CAPACITY];
    logic [WEIGHT_W-1:0] weight_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            sym_mem[req.waddr]    <= req.wsym;
            weight_mem[req.waddr] <= req.wweight;
        end
        rd_sym    <= sym_mem[req.raddr];
        rd_weight <= weight_mem[req.raddr];
    end

endmodule

// File: rtl/sswt_div.sv
// Restoring divider that produces one quotient bit per cycle.
module sswt_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [sswt_pkg::DIVD_W-1:0]   dividend,
    input  logic [sswt_pkg::TOTAL_W-1:0]  divisor,
    output logic                          done,
    output logic [sswt_pkg::WEIGHT_W-1:0] quotient
);
    import sswt_pkg::*;

    logic                 run_reg,  run_next;
    logic                 done_reg, done_next;
    logic [DSTEP_W-1:0]   cnt_reg,  cnt_next;
    logic [TOTAL_W-1:0]   rem_reg,  rem_next;
    logic [DIVD_W-1:0]    quo_reg,  quo_next;
    logic [TOTAL_W-1:0]   dsr_reg,  dsr_next;
    logic [TOTAL_W:0]     trial;
    logic [TOTAL_W:0]     diff;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            // The shifted remainder stays below twice the divisor, so one subtract decides.
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[TOTAL_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TOTAL_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DSTEP_W'(DIVD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[WEIGHT_W-1:0];

endmodule

// File: rtl/sorted_symbol_weight_table_unit.sv
// Top level of the sorted symbol weight table: sequencer, entry store and divider.
// Clear and an out-of-range read finish straight from idle; a read in range goes through
// the evaluate state. An add searches, then moves the entry up; a new symbol is inserted
// at the bottom unless the table is full. Normalise sums the weights and, unless the total
// is zero, divides each entry by it. One item at a time: busy until the strobe.
// Reset clears the entry count and control state; the entry memories are not cleared.
module sorted_symbol_weight_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [sswt_pkg::SYM_W-1:0]    symbol,
    input  logic [sswt_pkg::WEIGHT_W-1:0] amount,
    input  logic [5:0]                    rank,
    output logic                          done,
    output logic [sswt_pkg::SYM_W-1:0]    out_symbol,
    output logic [sswt_pkg::WEIGHT_W-1:0] out_weight,
    output logic [sswt_pkg::CNT_W-1:0]    entry_count,
    output logic [1:0]                    status
);
    import sswt_pkg::*;
    `include "sorted_symbol_weight_table_unit_defines.svh"

    // Sequencer states. A memory read is a pair: a state that issues the address (idle for a get)
    // and an evaluate state that sees the registered read data.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SRCH_RD = 4'd1;
    localparam logic [3:0] S_SRCH_EV = 4'd2;
    localparam logic [3:0] S_BUB_RD  = 4'd3;
    localparam logic [3:0] S_BUB_EV  = 4'd4;
    localparam logic [3:0] S_GET_EV  = 4'd5;
    localparam logic [3:0] S_SUM_RD  = 4'd6;
    localparam logic [3:0] S_SUM_EV  = 4'd7;
    localparam logic [3:0] S_NRM_RD  = 4'd8;
    localparam logic [3:0] S_NRM_EV  = 4'd9;
    localparam logic [3:0] S_NRM_DIV = 4'd10;

    logic [3:0]          state_reg,  state_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [CNT_W-1:0]    idx_reg,    idx_next;
    logic [SYM_W-1:0]    sym_reg,    sym_next;
    logic [WEIGHT_W-1:0] wgt_reg,    wgt_next;
    logic [WEIGHT_W-1:0] amt_reg,    amt_next;
    logic [TOTAL_W-1:0]  total_reg,  total_next;
    logic                done_reg,   done_next;
    logic [SYM_W-1:0]    osym_reg,   osym_next;
    logic [WEIGHT_W-1:0] owgt_reg,   owgt_next;
    logic [1:0]          ostat_reg,  ostat_next;

    mem_req_t            req;
    logic [SYM_W-1:0]    rd_sym;
    logic [WEIGHT_W-1:0] rd_weight;
    logic                div_go;
    logic                div_done;
    logic [WEIGHT_W-1:0] div_q;
    logic [WEIGHT_W:0]   sat_sum;
    logic [CNT_W-1:0]    idx_dec;

    sswt_store u_store (
        .clk       (clk),
        .req       (req),
        .rd_sym    (rd_sym),
        .rd_weight (rd_weight)
    );

    sswt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend ({rd_weight, FRAC_W'(0)}),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sat_sum = {1'b0, rd_weight} + {1'b0, amt_reg};
    assign idx_dec = idx_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        sym_next    = sym_reg;
        wgt_next    = wgt_reg;
        amt_next    = amt_reg;
        total_next  = total_reg;
        done_next   = 1'b0;
        osym_next   = osym_reg;
        owgt_next   = owgt_reg;
        ostat_next  = ostat_reg;
        div_go      = 1'b0;
        req.we      = 1'b0;
        req.waddr   = idx_reg[IDX_W-1:0];
        req.wsym    = sym_reg;
        req.wweight = wgt_reg;
        req.raddr   = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sym_next   = symbol;
                    amt_next   = amount;
                    idx_next   = '0;
                    osym_next  = '0;
                    owgt_next  = '0;
                    ostat_next = ST_OK;
                    unique case (opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        OP_ADD:
                        begin
                            state_next = S_SRCH_RD;
                        end
                        OP_GET:
                        begin
                            req.raddr = rank[IDX_W-1:0];
                            if ({1'b0, rank} < count_reg)
                            begin
                                state_next = S_GET_EV;
                            end
                            else
                            begin
                                ostat_next = ST_RANGE;
                                done_next  = 1'b1;
                            end
                        end
                        OP_NORM:
                        begin
                            total_next = '0;
                            state_next = S_SUM_RD;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    // Symbol not present: insert it from the bottom of the table.
                    if (count_reg == CNT_W'(CAPACITY))
                    begin
                        ostat_next = ST_FULL;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        wgt_next   = amt_reg;
                        count_next = count_reg + 1'b1;
                        state_next = S_BUB_RD;
                    end
                end
                else
                begin
                    state_next = S_SRCH_EV;
                end
            end
            S_SRCH_EV:
            begin
                if (rd_sym == sym_reg)
                begin
                    wgt_next   = sat_sum[WEIGHT_W] ? '1 : sat_sum[WEIGHT_W-1:0];
                    state_next = S_BUB_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
            end
            S_BUB_RD:
            begin
                req.raddr = idx_dec[IDX_W-1:0];
                if (idx_reg == '0)
                begin
                    req.we     = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_BUB_EV;
                end
            end
            S_BUB_EV:
            begin
                // The held entry moves up only past strictly lighter entries.
                req.we = 1'b1;
                if (wgt_reg > rd_weight)
                begin
                    req.wsym    = rd_sym;
                    req.wweight = rd_weight;
                    idx_next    = idx_dec;
                    state_next  = S_BUB_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_GET_EV:
            begin
                osym_next  = rd_sym;
                owgt_next  = rd_weight;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SUM_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    idx_next = '0;
                    if (total_reg == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_NRM_RD;
                    end
                end
                else
                begin
                    state_next = S_SUM_EV;
                end
            end
            S_SUM_EV:
            begin
                total_next = total_reg + TOTAL_W'(rd_weight);
                idx_next   = idx_reg + 1'b1;
                state_next = S_SUM_RD;
            end
            S_NRM_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_NRM_EV;
                end
            end
            S_NRM_EV:
            begin
                div_go     = 1'b1;
                state_next = S_NRM_DIV;
            end
            S_NRM_DIV:
            begin
                if (div_done)
                begin
                    req.we      = 1'b1;
                    req.wsym    = rd_sym;
                    req.wweight = div_q;
                    idx_next    = idx_reg + 1'b1;
                    state_next  = S_NRM_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        sym_reg   <= sym_next;
        wgt_reg   <= wgt_next;
        amt_reg   <= amt_next;
        total_reg <= total_next;
        osym_reg  <= osym_next;
        owgt_reg  <= owgt_next;
        ostat_reg <= ostat_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign out_symbol  = osym_reg;
    assign out_weight  = owgt_reg;
    assign status      = ostat_reg;
    assign entry_count = count_reg;

    // Every result is produced on the way back to idle.
    `SSWT_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    // An accepted item either starts work or finishes at once.
    `SSWT_ASSERT_NEXT(a_start_moves, clk, rst_n, start && !busy, busy || done)
    // The table never holds more entries than it has room for.
    `SSWT_ASSERT_IMPL(a_count_cap, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    // A full status is only reported when the table really is full.
    `SSWT_ASSERT_IMPL(a_full_real, clk, rst_n, done && (status == ST_FULL),
        entry_count == CNT_W'(CAPACITY))

endmodule

// File: tb/sv/tb_sorted_symbol_weight_table_unit.sv
// Self-checking testbench for the sorted symbol weight table unit.
module tb_sorted_symbol_weight_table_unit;

    import sswt_pkg::*;

    // One command as presented on the input ports. A hold item is not sent
    // until every result that is still outstanding has come back.
    typedef struct {
        logic [1:0]          op;
        logic [SYM_W-1:0]    sym;
        logic [WEIGHT_W-1:0] amt;
        logic [5:0]          rnk;
        bit                  hold;
    } cmd_t;

    // One result as seen on the output ports.
    typedef struct {
        logic [SYM_W-1:0]    sym;
        logic [WEIGHT_W-1:0] wt;
        logic [CNT_W-1:0]    cnt;
        logic [1:0]          st;
    } reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [1:0]          opcode = OP_CLEAR;
    logic [SYM_W-1:0]    symbol = '0;
    logic [WEIGHT_W-1:0] amount = '0;
    logic [5:0]          rank = '0;
    logic                busy;
    logic                done;
    logic [SYM_W-1:0]    out_symbol;
    logic [WEIGHT_W-1:0] out_weight;
    logic [CNT_W-1:0]    entry_count;
    logic [1:0]          status;

    cmd_t   pending_cmds[$];
    reply_t expected_replies[$];
    cmd_t   cur_cmd;
    int     idle_left = 0;
    int     sent_count = 0;
    int     error_count = 0;

    // Shadow copy of the table, kept in rank order exactly as the block does.
    logic [SYM_W-1:0]    shadow_sym[CAPACITY];
    logic [WEIGHT_W-1:0] shadow_wt[CAPACITY];
    int                  shadow_cnt = 0;

    sorted_symbol_weight_table_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .symbol      (symbol),
        .amount      (amount),
        .rank        (rank),
        .done        (done),
        .out_symbol  (out_symbol),
        .out_weight  (out_weight),
        .entry_count (entry_count),
        .status      (status)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Applies one accepted command to the shadow table and queues the reply
    // that the block must return for it.
    task automatic apply_to_shadow(input cmd_t c);
        reply_t                r;
        int                    i;
        int                    pos;
        bit                    found;
        logic [WEIGHT_W:0]     sum;
        logic [WEIGHT_W-1:0]   tw;
        logic [SYM_W-1:0]      ts;
        logic [63:0]           total;
        r = '{sym: '0, wt: '0, cnt: '0, st: ST_OK};
        found = 1'b0;
        case (c.op)
            OP_CLEAR:
            begin
                shadow_cnt = 0;
            end
            OP_ADD:
            begin
                for (i = 0; i < shadow_cnt && !found; i++)
                begin
                    if (shadow_sym[i] == c.sym)
                    begin
                        found = 1'b1;
                        sum = {1'b0, shadow_wt[i]} + {1'b0, c.amt};
                        // The weight saturates instead of wrapping.
                        shadow_wt[i] = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
                        pos = i;
                        // Move up only while strictly heavier than the entry above.
                        while (pos > 0 && shadow_wt[pos] > shadow_wt[pos-1])
                        begin
                            tw = shadow_wt[pos-1];
                            ts = shadow_sym[pos-1];
                            shadow_wt[pos-1] = shadow_wt[pos];
                            shadow_sym[pos-1] = shadow_sym[pos];
                            shadow_wt[pos] = tw;
                            shadow_sym[pos] = ts;
                            pos--;
                        end
                    end
                end
                if (!found)
                begin
                    if (shadow_cnt >= CAPACITY)
                    begin
                        r.st = ST_FULL;
                    end
                    else
                    begin
                        // A new entry lands after every entry of equal or greater weight.
                        pos = 0;
                        while (pos < shadow_cnt && shadow_wt[pos] >= c.amt)
                            pos++;
                        for (i = shadow_cnt; i > pos; i--)
                        begin
                            shadow_wt[i] = shadow_wt[i-1];
                            shadow_sym[i] = shadow_sym[i-1];
                        end
                        shadow_wt[pos] = c.amt;
                        shadow_sym[pos] = c.sym;
                        shadow_cnt++;
                    end
                end
            end
            OP_GET:
            begin
                if (c.rnk < shadow_cnt)
                begin
                    r.sym = shadow_sym[c.rnk];
                    r.wt = shadow_wt[c.rnk];
                end
                else
                begin
                    r.st = ST_RANGE;
                end
            end
            default:
            begin
                total = '0;
                for (i = 0; i < shadow_cnt; i++)
                    total += 64'(shadow_wt[i]);
                // An all-zero table is left untouched.
                if (total != 0)
                begin
                    for (i = 0; i < shadow_cnt; i++)
                        shadow_wt[i] = WEIGHT_W'((64'(shadow_wt[i]) << FRAC_W) / total);
                end
            end
        endcase
        r.cnt = CNT_W'(shadow_cnt);
        expected_replies.push_back(r);
    endtask

    // Sender. An item stays on the ports until the block takes it; between
    // items the sender may idle for a random burst of cycles.
    always @(posedge clk)
    begin
        bit   taken;
        cmd_t c;
        if (rst_n)
        begin
            taken = start && !busy;
            if (taken)
            begin
                apply_to_shadow(cur_cmd);
                sent_count++;
                // The last part of the run goes without any idling.
                if (sent_count < 500 && $urandom_range(0, 3) == 0)
                    idle_left = $urandom_range(1, 16);
            end
            if (!start || taken)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].hold && expected_replies.size() > 0))
                begin
                    c = pending_cmds.pop_front();
                    cur_cmd <= c;
                    opcode <= c.op;
                    symbol <= c.sym;
                    amount <= c.amt;
                    rank <= c.rnk;
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every strobed result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected result sym=%0h wt=%0h cnt=%0d st=%0d", $time,
                         out_symbol, out_weight, entry_count, status);
                error_count++;
            end
            else
            begin
                e = expected_replies.pop_front();
                if (out_symbol !== e.sym)
                begin
                    $display("%0t: out_symbol expected %0h actual %0h", $time, e.sym,
                             out_symbol);
                    error_count++;
                end
                if (out_weight !== e.wt)
                begin
                    $display("%0t: out_weight expected %0h actual %0h", $time, e.wt,
                             out_weight);
                    error_count++;
                end
                if (entry_count !== e.cnt)
                begin
                    $display("%0t: entry_count expected %0d actual %0d", $time, e.cnt,
                             entry_count);
                    error_count++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    error_count++;
                end
            end
        end
    end

    task automatic push_cmd(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                            input logic [WEIGHT_W-1:0] amt, input logic [5:0] rnk,
                            input bit hold);
        cmd_t c;
        c = '{op: op, sym: sym, amt: amt, rnk: rnk, hold: hold};
        pending_cmds.push_back(c);
    endtask

    // Weight increments lean toward small and repeated values so that ties,
    // promotions and saturation all occur often.
    function automatic logic [WEIGHT_W-1:0] pick_amount();
        case ($urandom_range(0, 5))
            0: pick_amount = '0;
            1: pick_amount = $urandom_range(1, 8);
            2: pick_amount = $urandom_range(0, 65535);
            3: pick_amount = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: pick_amount = $urandom;
        endcase
    endfunction

    // A run of commands on one table: mostly adds over a pool of symbols,
    // with reads at random ranks and an occasional normalise or clear.
    task automatic queue_session(input int len, input int pool_lo, input int pool_sz,
                                 input bit hold_first);
        int k;
        int pick;
        for (k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                push_cmd(OP_ADD, SYM_W'(pool_lo + $urandom_range(0, pool_sz - 1)),
                         pick_amount(), 6'($urandom), hold_first && k == 0);
            else if (pick < 92)
                push_cmd(OP_GET, SYM_W'($urandom), '0, 6'($urandom_range(0, 63)),
                         hold_first && k == 0);
            else if (pick < 97)
                push_cmd(OP_NORM, SYM_W'($urandom), $urandom, 6'($urandom),
                         hold_first && k == 0);
            else
                push_cmd(OP_CLEAR, SYM_W'($urandom), $urandom, 6'($urandom),
                         hold_first && k == 0);
        end
    endtask

    initial
    begin
        int s;
        // Directed part: empty reads, saturation, zero amounts, ties, promotion,
        // normalise of an all-zero table and of a mixed one.
        push_cmd(OP_GET, 8'h00, '0, 6'd0, 1'b0);
        push_cmd(OP_GET, 8'hFF, '1, 6'd63, 1'b0);
        push_cmd(OP_CLEAR, 8'h00, '0, 6'd0, 1'b0);
        push_cmd(OP_ADD, 8'h00, '0, 6'd0, 1'b0);
        push_cmd(OP_ADD, 8'h00, '0, 6'd0, 1'b0);
        push_cmd(OP_NORM, 8'h00, '0, 6'd0, 1'b0);
        push_cmd(OP_GET, 8'h00, '0, 6'd0, 1'b0);
        push_cmd(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 6'd0, 1'b0);
        push_cmd(OP_ADD, 8'hFF, 32'd5, 6'd0, 1'b0);
        push_cmd(OP_ADD, 8'h09, 32'd100, 6'd0, 1'b0);
        push_cmd(OP_ADD, 8'h0A, 32'd100, 6'd0, 1'b0);
        push_cmd(OP_ADD, 8'h0B, 32'd0, 6'd0, 1'b0);
        push_cmd(OP_ADD, 8'h0A, 32'd1, 6'd0, 1'b0);
        push_cmd(OP_ADD, 8'h0B, 32'd101, 6'd0, 1'b0);
        push_cmd(OP_GET, 8'h00, '0, 6'd1, 1'b0);
        push_cmd(OP_GET, 8'h00, '0, 6'd2, 1'b0);
        push_cmd(OP_GET, 8'h00, '0, 6'd3, 1'b0);
        push_cmd(OP_GET, 8'h00, '0, 6'd4, 1'b0);
        push_cmd(OP_GET, 8'h00, '0, 6'd5, 1'b0);
        push_cmd(OP_NORM, 8'h00, '0, 6'd0, 1'b0);
        push_cmd(OP_GET, 8'h00, '0, 6'd0, 1'b0);
        push_cmd(OP_GET, 8'h00, '0, 6'd4, 1'b0);
        push_cmd(OP_CLEAR, 8'hAA, 32'h5555_5555, 6'd42, 1'b1);

        // Random part. The wide pools bring in many distinct symbols, and the table is cleared
        // after each run; narrow pools give many promotions and saturations.
        for (s = 0; s < 9; s++)
        begin
            case (s % 3)
                0: queue_session(85, $urandom_range(0, 160), 90, 1'b1);
                1: queue_session(45, $urandom_range(0, 250), 6, 1'b0);
                default: queue_session(45, 0, 256, 1'b1);
            endcase
            push_cmd(OP_CLEAR, SYM_W'($urandom), $urandom, 6'($urandom), 1'b0);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start || expected_replies.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Guard against a hang: the slowest correct run stays far below this.
    initial
    begin
        #400000000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/sswt_pkg.sv
rtl/sswt_store.sv
rtl/sswt_div.sv
rtl/sorted_symbol_weight_table_unit.sv
tb/sv/tb_sorted_symbol_weight_table_unit.sv
